// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Baxter permutation checker: request and result types, constants.
// Depends on nothing; the top level and bpc_verdict refer to it by scoped names.
package bpc_pkg;

  // Width of one permutation entry as it arrives on the request port.
  localparam int unsigned ValueWidth = 9;

  // Permutations shorter than this always pass.
  localparam int unsigned MinLen = 4;

  // One request: a permutation entry and the end-of-permutation flag.
  typedef struct packed {
    logic [ValueWidth-1:0] perm_value;
    logic                  last_value;
  } req_t;

  // One result: the verdict and the overflow flag.
  typedef struct packed {
    logic is_baxter;
    logic too_long;
  } res_t;

  // Status from the verdict sequencer back to the top level.
  typedef struct packed {
    logic done;
    logic pass;
  } vfy_sts_t;

endpackage

// ===== rtl/baxter_permutation_check.sv =====
`timescale 1ns / 1ps
// Top level of the Baxter permutation checker: request load, the two stores and
// the result register. Depends on bpc_pkg, bpc_ram and bpc_verdict.
//
// Channel   Direction  Handshake             Payload
// request   in         start && !busy        req_i (perm_value, last_value)
// result    out        valid_o, one cycle    res_o (is_baxter, too_long)
//
// A request without the last flag is accepted and busy stays low.
// A request with the last flag raises busy for the check, which reads both positions of each
// value pair and scans any entries between them through the single read port of each store;
// a failing entry ends the check at once.
// The result strobe comes in the cycle busy falls. Reset clears the control state only.
// The receiver cannot stall: valid_o is high for exactly one cycle.
module baxter_permutation_check #(
  parameter int unsigned N_MAX = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bpc_pkg::req_t     req_i,
  output logic              valid_o,
  output bpc_pkg::res_t     res_o
);

  localparam int unsigned EAW = $clog2(N_MAX);
  localparam int unsigned CW  = $clog2(N_MAX + 1);

  logic                            accept;
  logic                            has_room;
  logic                            val_ok;
  logic [CW-1:0]                   count_q, count_d;
  logic                            ovf_q, ovf_d;
  logic                            busy_q, busy_d;
  logic                            valid_q, valid_d;
  bpc_pkg::res_t                   res_q, res_d;
  logic                            go;

  logic                            pos_re;
  logic [CW-1:0]                   pos_raddr;
  logic [EAW-1:0]                  pos_rdata;
  logic                            ent_re;
  logic [EAW-1:0]                  ent_raddr;
  logic [bpc_pkg::ValueWidth-1:0]  ent_rdata;
  bpc_pkg::vfy_sts_t               sts;

  // Request acceptance and store writes.
  assign accept   = start && !busy_q;
  assign has_room = 32'(count_q) < N_MAX;
  assign val_ok   = (req_i.perm_value != '0) && (32'(req_i.perm_value) <= N_MAX);
  assign go       = accept && req_i.last_value;

  bpc_ram #(
    .WIDTH(bpc_pkg::ValueWidth),
    .DEPTH(N_MAX)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (accept && has_room),
    .waddr_i(count_q[EAW-1:0]),
    .wdata_i(req_i.perm_value),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  bpc_ram #(
    .WIDTH(EAW),
    .DEPTH(N_MAX + 1)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (accept && has_room && val_ok),
    .waddr_i(CW'(32'(req_i.perm_value))),
    .wdata_i(count_q[EAW-1:0]),
    .re_i   (pos_re),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  bpc_verdict #(
    .N_MAX(N_MAX)
  ) u_verdict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .n_i        (count_d),
    .pos_re_o   (pos_re),
    .pos_raddr_o(pos_raddr),
    .pos_rdata_i(pos_rdata),
    .ent_re_o   (ent_re),
    .ent_raddr_o(ent_raddr),
    .ent_rdata_i(ent_rdata),
    .sts_o      (sts)
  );

  // Count, overflow and result bookkeeping.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    valid_d = 1'b0;
    res_d   = res_q;
    if (accept) begin
      if (has_room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (go) begin
      busy_d = 1'b1;
    end
    if (sts.done) begin
      busy_d          = 1'b0;
      valid_d         = 1'b1;
      res_d.is_baxter = sts.pass;
      res_d.too_long  = ovf_q;
      count_d         = '0;
      ovf_d           = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy    = busy_q;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // A last-flagged request always starts a check.
  a_last_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.last_value) |=> busy)
    else $error("check did not start after the last entry");

  // The end of a check always delivers exactly one result.
  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("check ended without a result");

  // Results never come back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  // No result appears while a check is still running.
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result issued while busy");

endmodule

// ===== rtl/bpc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bpc_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/bpc_verdict.sv =====
`timescale 1ns / 1ps
// Verdict sequencer: walks each value pair, reads both positions, then scans the
// entries between them through one shared compare unit. Depends on bpc_pkg.
module bpc_verdict #(
  parameter int unsigned N_MAX = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [$clog2(N_MAX+1)-1:0] n_i,
  output logic                       pos_re_o,
  output logic [$clog2(N_MAX+1)-1:0] pos_raddr_o,
  input  logic [$clog2(N_MAX)-1:0]   pos_rdata_i,
  output logic                       ent_re_o,
  output logic [$clog2(N_MAX)-1:0]   ent_raddr_o,
  input  logic [bpc_pkg::ValueWidth-1:0] ent_rdata_i,
  output bpc_pkg::vfy_sts_t          sts_o
);

  localparam int unsigned EAW = $clog2(N_MAX);
  localparam int unsigned CW  = $clog2(N_MAX + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_PV    = 3'd2;
  localparam logic [2:0] S_PW    = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  v_q, v_d;
  logic [EAW-1:0] pv_q, pv_d;
  logic [EAW-1:0] idx_q, idx_d;
  logic [EAW-1:0] hi_q, hi_d;
  logic           dir_q, dir_d;
  logic           seen_q, seen_d;
  logic           rdv_q, rdv_d;

  logic [CW-1:0]  v_next;
  logic [CW-1:0]  pv_ext, pw_ext;
  logic           e_gt, e_lt;
  logic           hit_seen, hit_fail;

  // Shared compare unit: the entry just read against the current value.
  assign e_gt = 32'(ent_rdata_i) > 32'(v_q);
  assign e_lt = 32'(ent_rdata_i) < 32'(v_q);

  // Which side counts as "seen" and which as a failure depends on the order of v and v+1.
  assign hit_seen = dir_q ? e_lt : e_gt;
  assign hit_fail = dir_q ? e_gt : e_lt;

  assign v_next = v_q + CW'(1);
  assign pv_ext = CW'(pv_q);
  assign pw_ext = CW'(pos_rdata_i);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    v_d         = v_q;
    pv_d        = pv_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    dir_d       = dir_q;
    seen_d      = seen_q;
    rdv_d       = rdv_q;
    pos_re_o    = 1'b0;
    pos_raddr_o = v_q;
    ent_re_o    = 1'b0;
    ent_raddr_o = idx_q;
    sts_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          n_d     = n_i;
          state_d = S_START;
        end
      end
      S_START: begin
        if (32'(n_q) < bpc_pkg::MinLen) begin
          sts_o.done = 1'b1;
          sts_o.pass = 1'b1;
          state_d    = S_IDLE;
        end else begin
          v_d     = CW'(1);
          state_d = S_PV;
        end
      end
      S_PV: begin
        pos_re_o    = 1'b1;
        pos_raddr_o = v_q;
        state_d     = S_PW;
      end
      S_PW: begin
        pos_re_o    = 1'b1;
        pos_raddr_o = v_next;
        pv_d        = pos_rdata_i;
        state_d     = S_CMP;
      end
      S_CMP: begin
        seen_d = 1'b0;
        rdv_d  = 1'b0;
        if (pv_ext < n_q && pw_ext < n_q && pw_ext > pv_ext + CW'(1)) begin
          // v comes first.
          dir_d   = 1'b0;
          idx_d   = pv_q + EAW'(1);
          hi_d    = pos_rdata_i;
          state_d = S_SCAN;
        end else if (pv_ext < n_q && pw_ext < n_q && pv_ext > pw_ext + CW'(1)) begin
          // v+1 comes first.
          dir_d   = 1'b1;
          idx_d   = pos_rdata_i + EAW'(1);
          hi_d    = pv_q;
          state_d = S_SCAN;
        end else if (v_next >= n_q) begin
          sts_o.done = 1'b1;
          sts_o.pass = 1'b1;
          state_d    = S_IDLE;
        end else begin
          v_d     = v_next;
          state_d = S_PV;
        end
      end
      S_SCAN: begin
        // Issue the next read while the previous entry is evaluated.
        if (idx_q != hi_q) begin
          ent_re_o = 1'b1;
          idx_d    = idx_q + EAW'(1);
          rdv_d    = 1'b1;
        end else begin
          rdv_d = 1'b0;
        end
        if (rdv_q && hit_fail && seen_q) begin
          sts_o.done = 1'b1;
          sts_o.pass = 1'b0;
          state_d    = S_IDLE;
        end else begin
          if (rdv_q) begin
            seen_d = seen_q | hit_seen;
          end
          if (!rdv_q && idx_q == hi_q) begin
            if (v_next >= n_q) begin
              sts_o.done = 1'b1;
              sts_o.pass = 1'b1;
              state_d    = S_IDLE;
            end else begin
              v_d     = v_next;
              state_d = S_PV;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdv_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      seen_q  <= seen_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    v_q   <= v_d;
    pv_q  <= pv_d;
    idx_q <= idx_d;
    hi_q  <= hi_d;
    dir_q <= dir_d;
  end

endmodule

// ===== tb/sv/baxter_permutation_check_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Baxter permutation checker: watches the request and result channels,
// predicts each verdict and compares it. Depends on bpc_pkg.
module baxter_permutation_check_checker #(
  parameter int unsigned N_MAX = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  bpc_pkg::req_t req_i,
  input  logic          valid_i,
  input  bpc_pkg::res_t res_i,
  output int unsigned   mismatches_o,
  output int unsigned   outstanding_o
);

  // Shadow copy of the two stores and the load state.
  logic [bpc_pkg::ValueWidth-1:0] entry_at [N_MAX];
  int unsigned                    slot_of_value [1:N_MAX];
  int unsigned                    stored_cnt;
  logic                           dropped;

  // Verdicts still owed by the block, oldest first.
  bpc_pkg::res_t verdict_q[$];

  // Walks every value pair and scans the entries between their positions.
  function automatic logic predict_baxter();
    int unsigned n, v, pv, pw, i, e;
    logic seen;
    n = stored_cnt;
    if (n < bpc_pkg::MinLen) return 1'b1;
    for (v = 1; v < n; v++) begin
      pv = slot_of_value[v];
      pw = slot_of_value[v + 1];
      seen = 1'b0;
      // A pair with a stale position outside the current length passes.
      if (pv >= n || pw >= n) continue;
      if (pw > pv + 1) begin
        // Smaller value first: a larger entry followed by a smaller one fails.
        for (i = pv + 1; i < pw; i++) begin
          e = 32'(entry_at[i]);
          if (e > v) seen = 1'b1;
          if (e < v && seen) return 1'b0;
        end
      end else if (pv > pw + 1) begin
        // Larger value first: a smaller entry followed by a larger one fails.
        for (i = pw + 1; i < pv; i++) begin
          e = 32'(entry_at[i]);
          if (e < v) seen = 1'b1;
          if (e > v && seen) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Stores one accepted request; the final one of a permutation owes a verdict.
  function automatic void take_request(bpc_pkg::req_t r);
    bpc_pkg::res_t outcome;
    if (stored_cnt < N_MAX) begin
      entry_at[stored_cnt] = r.perm_value;
      // Values outside 1..N_MAX get no position.
      if (32'(r.perm_value) >= 1 && 32'(r.perm_value) <= N_MAX) begin
        slot_of_value[r.perm_value] = stored_cnt;
      end
      stored_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (r.last_value) begin
      outcome.is_baxter = predict_baxter();
      outcome.too_long  = dropped;
      verdict_q.push_back(outcome);
      stored_cnt = 0;
      dropped    = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches_o++;
    if (mismatches_o <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Compares a result strobe with the oldest owed verdict, field by field.
  function automatic void check_result(bpc_pkg::res_t got);
    bpc_pkg::res_t want;
    if (verdict_q.size() == 0) begin
      note_mismatch($sformatf("result with no request owed: is_baxter=%b too_long=%b",
                              got.is_baxter, got.too_long));
    end else begin
      want = verdict_q.pop_front();
      if (got.is_baxter !== want.is_baxter) begin
        note_mismatch($sformatf("is_baxter expected %b, got %b",
                                want.is_baxter, got.is_baxter));
      end
      if (got.too_long !== want.too_long) begin
        note_mismatch($sformatf("too_long expected %b, got %b",
                                want.too_long, got.too_long));
      end
    end
  endfunction

  // Results are checked before a request of the same edge is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_cnt   = 0;
      dropped      = 1'b0;
      mismatches_o = 0;
      verdict_q.delete();
    end else begin
      if (valid_i) check_result(res_i);
      if (start_i && !busy_i) take_request(req_i);
    end
    outstanding_o = verdict_q.size();
  end

endmodule

// ===== tb/sv/baxter_permutation_check_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the Baxter permutation checker: clock, reset, request stimulus
// and the verdict. Depends on bpc_pkg, baxter_permutation_check and its checker.
module baxter_permutation_check_tb;

  localparam int unsigned SlotCount   = 256;
  localparam int unsigned RandomItems = 1380;
  localparam int unsigned DrainLimit  = 300000;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  bpc_pkg::req_t req_i;
  logic          valid_o;
  bpc_pkg::res_t res_o;
  int unsigned   mismatches;
  int unsigned   outstanding;

  // Permutation being sent, and the sender's idle rate in percent.
  logic [bpc_pkg::ValueWidth-1:0] perm_buf[$];
  int unsigned                    sender_idle_pct;

  baxter_permutation_check #(
    .N_MAX(SlotCount)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  baxter_permutation_check_checker #(
    .N_MAX(SlotCount)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .valid_i      (valid_o),
    .res_i        (res_o),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("baxter_permutation_check_tb: done, errors");
    $finish;
  end

  // Fills perm_buf with a permutation of 1..n: shuffled, or sorted either way
  // with a few neighbor swaps so that Baxter permutations stay common.
  function automatic void fill_perm(int unsigned n, bit near_sorted);
    int unsigned i, j;
    logic [bpc_pkg::ValueWidth-1:0] t;
    bit desc;
    desc = near_sorted && ($urandom_range(1) == 1);
    perm_buf.delete();
    for (i = 1; i <= n; i++) perm_buf.push_back(9'(desc ? n + 1 - i : i));
    if (near_sorted) begin
      if (n >= 2) begin
        repeat ($urandom_range(0, 3)) begin
          j = $urandom_range(0, n - 2);
          t = perm_buf[j];
          perm_buf[j] = perm_buf[j + 1];
          perm_buf[j + 1] = t;
        end
      end
    end else begin
      for (i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm_buf[i];
        perm_buf[i] = perm_buf[j];
        perm_buf[j] = t;
      end
    end
  endfunction

  // Broken sequences: duplicates, gaps, zero and values past the store range.
  function automatic void fill_noise(int unsigned n);
    int unsigned i, pick;
    perm_buf.delete();
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) perm_buf.push_back(9'($urandom_range(1, n)));
      else if (pick < 80) perm_buf.push_back('0);
      else if (pick < 90) perm_buf.push_back(9'($urandom_range(SlotCount + 1, 511)));
      else perm_buf.push_back(9'($urandom_range(1, SlotCount)));
    end
  endfunction

  // Sends one request and returns at the edge that accepts it.
  task automatic send_entry(input logic [bpc_pkg::ValueWidth-1:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{perm_value: value, last_value: last};
    do @(posedge clk_i); while (busy);
  endtask

  // Sends perm_buf with the last flag on its final entry.
  task automatic send_perm();
    int unsigned k;
    for (k = 0; k < perm_buf.size(); k++) send_entry(perm_buf[k], k == perm_buf.size() - 1);
  endtask

  initial begin : stimulus
    int unsigned sent, seq_idx, kind, pick, len, drain;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    sender_idle_pct = 37;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lengths below four always pass, one sorted permutation, the two
    // non-Baxter patterns of length four, and entries of zero, all ones and just
    // past the store range, which get no position.
    perm_buf = {9'd1};
    send_perm();
    perm_buf = {9'd2, 9'd1};
    send_perm();
    perm_buf = {9'd3, 9'd1, 9'd2};
    send_perm();
    perm_buf = {9'd1, 9'd2, 9'd3, 9'd4};
    send_perm();
    perm_buf = {9'd2, 9'd4, 9'd1, 9'd3};
    send_perm();
    perm_buf = {9'd3, 9'd1, 9'd4, 9'd2};
    send_perm();
    perm_buf = {9'd0, 9'd1, 9'd2, 9'd3};
    send_perm();
    perm_buf = {9'd511, 9'd257, 9'd2, 9'd1};
    send_perm();

    // Random: a full-length permutation first so every value has a position,
    // then an overfull one, then mostly permutations with some noise.
    sent    = 0;
    seq_idx = 0;
    while (sent < RandomItems) begin
      if (sent < RandomItems / 3) sender_idle_pct = 37;
      else if (sent < 2 * RandomItems / 3) sender_idle_pct = 80;
      else sender_idle_pct = 0;
      kind = $urandom_range(99);
      if (seq_idx == 0) begin
        fill_perm(SlotCount, 1'b0);
      end else if (seq_idx == 1 || kind < 2) begin
        // More entries than the store holds; the last one is dropped too.
        fill_perm(SlotCount, 1'b0);
        repeat ($urandom_range(1, 4)) perm_buf.push_back(9'($urandom_range(1, SlotCount)));
      end else if (kind < 20) begin
        fill_noise($urandom_range(1, 24));
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(4, 10);
        else if (pick < 90) len = $urandom_range(1, 48);
        else if (pick < 98) len = $urandom_range(49, 160);
        else len = SlotCount;
        fill_perm(len, $urandom_range(1) == 1);
      end
      send_perm();
      sent += perm_buf.size();
      seq_idx++;
    end
    start <= 1'b0;

    // Wait for every owed verdict, then a little longer for stray strobes.
    drain = 0;
    do begin
      @(negedge clk_i);
      drain++;
    end while (outstanding != 0 && drain < DrainLimit);
    repeat (50) @(negedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("baxter_permutation_check_tb: done, clean");
    end else begin
      $display("baxter_permutation_check_tb: done, errors");
    end
    $finish;
  end

endmodule
